>>> hdl/lfsa_pkg.sv
// lfsa_pkg: shared types and codes of the lifo free list slot allocator
// holds request/response structs, action and status codes, cell control struct
// no dependencies
package lfsa_pkg;

  localparam logic [2:0] ACT_ALLOC   = 3'd0;
  localparam logic [2:0] ACT_ARANGE  = 3'd1;
  localparam logic [2:0] ACT_FREE    = 3'd2;
  localparam logic [2:0] ACT_FRANGE  = 3'd3;
  localparam logic [2:0] ACT_LOOKUP  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_NORUN   = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;
  localparam logic [2:0] ST_DOUBLE  = 3'd5;

  localparam logic [2:0] CFG_CAPACITY  = 3'd0;
  localparam logic [2:0] CFG_SLOT_SIZE = 3'd1;
  localparam logic [2:0] CFG_HOST_BASE = 3'd2;
  localparam logic [2:0] CFG_SHDR_BASE = 3'd3;
  localparam logic [2:0] CFG_SHDR_VIS  = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [11:0] slot_index;
    logic        handle_valid;
    logic [10:0] slot_count;
  } lfsa_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot_out;
    logic [63:0] host_address;
    logic [63:0] shader_address;
    logic [10:0] used_count;
  } lfsa_rsp_t;

  // control shared by every cell of the stack chain
  typedef struct packed {
    logic reload;
    logic shift_dn;
    logic shift_up;
  } lfsa_cell_ctl_t;

endpackage

>>> hdl/lfsa_cell.sv
// lfsa_cell: one entry of the free slot stack chain
// depends on lfsa_pkg for the chain control struct
module lfsa_cell #(
  parameter int AW  = 10,
  parameter int IDX = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lfsa_pkg::lfsa_cell_ctl_t ctl_i,
  input  logic [AW-1:0]           prev_i,
  input  logic [AW-1:0]           next_i,
  input  logic                    ins_i,
  input  logic [AW-1:0]           ins_val_i,
  output logic [AW-1:0]           val_o
);
  import lfsa_pkg::*;

  logic [AW-1:0] val_q, val_d;

  // reload puts the refill order back, insert beats the shift
  always_comb begin
    val_d = val_q;
    if (ctl_i.reload) begin
      val_d = AW'(IDX);
    end else if (ins_i) begin
      val_d = ins_val_i;
    end else if (ctl_i.shift_dn) begin
      val_d = prev_i;
    end else if (ctl_i.shift_up) begin
      val_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= AW'(IDX);
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;
endmodule

>>> hdl/lfsa_map.sv
// lfsa_map: one bit per slot, set while the slot is free
// single write port, one registered read port; no dependencies
module lfsa_map #(
  parameter int AW = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);
  logic mem [2**AW];
  logic rdata_q;

  // write then registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> hdl/lifo_free_list_slot_allocator_core.sv
// lifo_free_list_slot_allocator_core: top level of the slot allocator
// depends on lfsa_pkg, lfsa_cell, lfsa_map
//
// usage: a request is taken when start is high and busy is low. each request
// gives exactly one response, shown on rsp_o for one cycle with rsp_valid_o;
// the receiver cannot stall it. configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while busy is low.
// errors found at decode answer in the cycle after the request; allocate and
// lookup answer after the decode (pop for allocate), multiply and add steps.
// free visits a read and a check state per slot (only the read state for a
// slot beyond capacity), then answers. range allocate of more than one slot
// scans the free map one slot a cycle and then rotates the stack chain once,
// one entry a cycle, then multiplies and adds for the address; the single map
// port and the one-entry-a-cycle chain set this pace.
// reset and every capacity write refill the stack at once and start a pass
// over all MAX_SLOTS entries of the free map, with busy high, before the first
// request is taken.
module lifo_free_list_slot_allocator_core #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  lfsa_pkg::lfsa_req_t req_i,
  output logic               rsp_valid_o,
  output lfsa_pkg::lfsa_rsp_t rsp_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);
  import lfsa_pkg::*;

  localparam int AW    = $clog2(MAX_SLOTS);
  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int RST_N = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SRCH, S_COMPACT, S_FR_RD, S_FR_CHK, S_MUL, S_SUM
  } state_e;

  state_e        state_q;
  logic [CW-1:0] n_q, depth_q, scan_q, chk_q, run_q, iter_q, clr_q;
  logic [12:0]   size_q;
  logic [63:0]   hbase_q, sbase_q;
  logic          svis_q;
  logic [10:0]   used_q, count_q, i_q;
  logic [AW-1:0] start_q, slot_q;
  logic          chk_vld_q;
  logic [12:0]   cur_q;
  logic [2:0]    st_q;
  logic [AW+12:0] prod_q;
  lfsa_rsp_t     rsp_q;
  logic          rsp_valid_q;

  logic          accept, pop1, fr_push, keep, cmp_step;
  logic [CW-1:0] eff_cap, run_nx;
  logic [AW-1:0] top;
  logic          map_we, map_wd, map_rd;
  logic [AW-1:0] map_wa, map_ra;
  lfsa_cell_ctl_t cell_ctl;
  logic [AW-1:0] cell_val [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] cell_ins;

  function automatic lfsa_rsp_t err_rsp(logic [2:0] st, logic [10:0] used);
    lfsa_rsp_t r;
    r = '0;
    r.status = st;
    r.used_count = used;
    return r;
  endfunction

  // effective capacity of a capacity write
  always_comb begin
    if (cfg_data_i[10:0] == 11'd0) begin
      eff_cap = CW'(1);
    end else if (32'(cfg_data_i[10:0]) > MAX_SLOTS) begin
      eff_cap = CW'(MAX_SLOTS);
    end else begin
      eff_cap = CW'(cfg_data_i[10:0]);
    end
  end

  // request decode and chain steps
  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign top      = cell_val[0];
  assign pop1     = accept && (depth_q != '0) &&
                    ((req_i.action == ACT_ALLOC) ||
                     ((req_i.action == ACT_ARANGE) && (req_i.slot_count == 11'd1)));
  assign fr_push  = (state_q == S_FR_CHK) && !map_rd;
  assign cmp_step = (state_q == S_COMPACT);
  assign keep     = !((32'(top) >= 32'(start_q)) &&
                      (32'(top) < 32'(start_q) + 32'(count_q)));
  assign run_nx   = map_rd ? run_q + CW'(1) : '0;

  assign cell_ctl.reload   = cfg_we_i && (cfg_idx_i == CFG_CAPACITY);
  assign cell_ctl.shift_dn = fr_push;
  assign cell_ctl.shift_up = pop1 || cmp_step;

  // stack chain, cell 0 is the top
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    logic [AW-1:0] prev_v, next_v;
    if (g == 0) begin : g_first
      assign prev_v = AW'(cur_q);
    end else begin : g_mid
      assign prev_v = cell_val[g-1];
    end
    if (g == MAX_SLOTS - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_nmid
      assign next_v = cell_val[g+1];
    end
    assign cell_ins[g] = cmp_step && keep && (32'(depth_q) == g + 1);
    lfsa_cell #(.AW(AW), .IDX(g)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (cell_ctl),
      .prev_i    (prev_v),
      .next_i    (next_v),
      .ins_i     (cell_ins[g]),
      .ins_val_i (top),
      .val_o     (cell_val[g])
    );
  end

  // free map port control
  always_comb begin
    map_we = 1'b0;
    map_wa = '0;
    map_wd = 1'b0;
    map_ra = AW'(cur_q);
    case (state_q)
      S_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr_q[AW-1:0];
        map_wd = 32'(clr_q) < 32'(n_q);
      end
      S_IDLE: begin
        map_we = pop1;
        map_wa = top;
      end
      S_SRCH: begin
        map_ra = scan_q[AW-1:0];
      end
      S_COMPACT: begin
        map_we = 32'(clr_q) < 32'(count_q);
        map_wa = AW'(32'(start_q) + 32'(clr_q));
      end
      S_FR_CHK: begin
        map_we = !map_rd;
        map_wa = AW'(cur_q);
        map_wd = 1'b1;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  lfsa_map #(.AW(AW)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_wa),
    .wdata_i (map_wd),
    .raddr_i (map_ra),
    .rdata_o (map_rd)
  );

  // sequencer, counters and registered response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      n_q         <= CW'(RST_N);
      depth_q     <= CW'(RST_N);
      used_q      <= '0;
      size_q      <= 13'd32;
      hbase_q     <= '0;
      sbase_q     <= '0;
      svis_q      <= 1'b0;
      clr_q       <= '0;
      scan_q      <= '0;
      chk_q       <= '0;
      chk_vld_q   <= 1'b0;
      run_q       <= '0;
      iter_q      <= '0;
      count_q     <= '0;
      i_q         <= '0;
      cur_q       <= '0;
      st_q        <= ST_OK;
      start_q     <= '0;
      slot_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + CW'(1);
          if (32'(clr_q) == MAX_SLOTS - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (req_i.action)
              ACT_ALLOC, ACT_ARANGE: begin
                if (req_i.action == ACT_ARANGE && req_i.slot_count == 11'd0) begin
                  rsp_q <= err_rsp(ST_INVALID, used_q);
                  rsp_valid_q <= 1'b1;
                end else if (pop1) begin
                  slot_q  <= top;
                  depth_q <= depth_q - CW'(1);
                  used_q  <= used_q + 11'd1;
                  state_q <= S_MUL;
                end else if ((req_i.action == ACT_ALLOC) ||
                             (32'(depth_q) < 32'(req_i.slot_count))) begin
                  rsp_q <= err_rsp(ST_FULL, used_q);
                  rsp_valid_q <= 1'b1;
                end else begin
                  count_q   <= req_i.slot_count;
                  scan_q    <= '0;
                  chk_vld_q <= 1'b0;
                  run_q     <= '0;
                  state_q   <= S_SRCH;
                end
              end
              ACT_FREE, ACT_FRANGE: begin
                if (!req_i.handle_valid) begin
                  rsp_q <= err_rsp(ST_OK, used_q);
                  rsp_valid_q <= 1'b1;
                end else begin
                  count_q <= (req_i.action == ACT_FREE) ? 11'd1 : req_i.slot_count;
                  cur_q   <= {1'b0, req_i.slot_index};
                  i_q     <= '0;
                  st_q    <= ST_OK;
                  state_q <= S_FR_RD;
                end
              end
              ACT_LOOKUP: begin
                if (32'(req_i.slot_index) >= 32'(n_q)) begin
                  rsp_q <= err_rsp(ST_RANGE, used_q);
                  rsp_valid_q <= 1'b1;
                end else begin
                  slot_q  <= AW'(req_i.slot_index);
                  state_q <= S_MUL;
                end
              end
              default: begin
                rsp_q <= err_rsp(ST_INVALID, used_q);
                rsp_valid_q <= 1'b1;
              end
            endcase
          end
        end
        S_SRCH: begin
          // issue the next map read, check the one that came back
          if (32'(scan_q) < 32'(n_q)) begin
            chk_q     <= scan_q;
            chk_vld_q <= 1'b1;
            scan_q    <= scan_q + CW'(1);
          end else begin
            chk_vld_q <= 1'b0;
          end
          if (chk_vld_q) begin
            run_q <= run_nx;
            if (32'(run_nx) >= 32'(count_q)) begin
              start_q <= AW'(32'(chk_q) - 32'(count_q) + 1);
              iter_q  <= depth_q;
              clr_q   <= '0;
              state_q <= S_COMPACT;
            end else if (32'(chk_q) == 32'(n_q) - 1) begin
              rsp_q <= err_rsp(ST_NORUN, used_q);
              rsp_valid_q <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_COMPACT: begin
          // rotate the chain once, dropping the run's slots
          depth_q <= keep ? depth_q : depth_q - CW'(1);
          if (32'(clr_q) < 32'(count_q)) begin
            clr_q <= clr_q + CW'(1);
          end
          iter_q <= iter_q - CW'(1);
          if (iter_q == CW'(1)) begin
            slot_q  <= start_q;
            used_q  <= used_q + count_q;
            state_q <= S_MUL;
          end
        end
        S_FR_RD: begin
          if (i_q == count_q) begin
            rsp_q <= err_rsp(st_q, used_q);
            rsp_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else if (32'(cur_q) >= 32'(n_q)) begin
            if (st_q == ST_OK) begin
              st_q <= ST_RANGE;
            end
            cur_q <= cur_q + 13'd1;
            i_q   <= i_q + 11'd1;
          end else begin
            state_q <= S_FR_CHK;
          end
        end
        S_FR_CHK: begin
          if (map_rd) begin
            if (st_q == ST_OK) begin
              st_q <= ST_DOUBLE;
            end
          end else begin
            used_q  <= used_q - 11'd1;
            depth_q <= depth_q + CW'(1);
          end
          cur_q   <= cur_q + 13'd1;
          i_q     <= i_q + 11'd1;
          state_q <= S_FR_RD;
        end
        S_MUL: begin
          prod_q  <= (AW+13)'(slot_q) * (AW+13)'(size_q);
          state_q <= S_SUM;
        end
        S_SUM: begin
          rsp_q.status         <= ST_OK;
          rsp_q.slot_out       <= 10'(slot_q);
          rsp_q.host_address   <= hbase_q + 64'(prod_q);
          rsp_q.shader_address <= svis_q ? sbase_q + 64'(prod_q) : 64'd0;
          rsp_q.used_count     <= used_q;
          rsp_valid_q          <= 1'b1;
          state_q              <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // register writes; the user must write them only while idle, the block does not enforce it
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CAPACITY: begin
            n_q     <= eff_cap;
            depth_q <= eff_cap;
            used_q  <= '0;
            clr_q   <= '0;
            state_q <= S_CLEAR;
          end
          CFG_SLOT_SIZE: size_q  <= cfg_data_i[12:0];
          CFG_HOST_BASE: hbase_q <= cfg_data_i;
          CFG_SHDR_BASE: sbase_q <= cfg_data_i;
          CFG_SHDR_VIS:  svis_q  <= cfg_data_i[0];
          default: begin
            svis_q <= svis_q;
          end
        endcase
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
endmodule
